>>> src/assert_macros.svh
// Assertion macros shared by the pitch corrector RTL.
// Included by files that carry concurrent checks; they expect i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that holds every cycle, disabled while reset is asserted.
`define DLPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Clocked check of the cycle after a condition, disabled while reset is asserted.
`define DLPC_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

>>> src/dlpc_pkg.sv
// Package for the delay-line pitch corrector: sizes, constants, tables,
// state type and arithmetic helpers. No dependencies.
package dlpc_pkg;

    localparam int DELAY_DEPTH      = 1024;
    localparam int WINDOW_SAMPLES   = 512;
    localparam int SINE_TABLE_DEPTH = 256;

    localparam int AW     = $clog2(DELAY_DEPTH);
    localparam int WIN_W  = $clog2(WINDOW_SAMPLES);
    localparam int SIN_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int PH_W   = 24;
    localparam int STEP_SH = 6 + WIN_W;
    localparam int DIV_STEPS = 4;

    localparam int CFG_IW = 1;
    localparam int CFG_DW = 25;
    localparam logic [CFG_IW-1:0] REG_RATIO_COEF = 1'd0;
    localparam logic [CFG_IW-1:0] REG_WET_COEF   = 1'd1;
    localparam logic [CFG_DW-1:0] RATIO_COEF_RST = 25'd5823;
    localparam logic [CFG_DW-1:0] WET_COEF_RST   = 25'd17459;
    localparam logic [CFG_DW-1:0] COEF_UNITY     = 25'd16777216;

    localparam logic signed [31:0] Q30_ONE    = 32'sd1073741824;
    localparam logic signed [31:0] RATIO_LOW  = 32'sd751619277;
    localparam logic signed [31:0] RATIO_HIGH = 32'sd1503238554;
    localparam logic [PH_W-1:0]    PHASE_HALF = 24'h800000;

    typedef enum logic [3:0] {
        S_IDLE, S_DIV, S_TGT, S_MR, S_MW, S_PH, S_RD0, S_TAP0, S_TAP1,
        S_G0, S_G1, S_Y, S_MX0, S_MX1, S_OUT
    } t_state;

    typedef enum logic [1:0] {TGT_ONE, TGT_HIGH, TGT_DIV} t_tgt_mode;

    typedef struct packed {
        logic [AW-1:0] i0;
        logic [AW-1:0] i1;
        logic [24:0]   w;
    } t_tap;

    typedef logic [15:0] t_gain_tab [SINE_TABLE_DEPTH];
    typedef logic [15:0] t_note_tab [128];

    function automatic logic [15:0] sine_entry(int unsigned i);
        logic [63:0] j, a, a2, term, s, r;
        j = (2 * i <= SINE_TABLE_DEPTH) ? 64'(i) : 64'(SINE_TABLE_DEPTH - i);
        a = 64'd3373259426 * j / SINE_TABLE_DEPTH;
        a2 = (a * a) >> 30;
        term = 64'd1 << 30;
        term = (64'd1 << 30) - ((a2 * term) >> 30) / 110;
        term = (64'd1 << 30) - ((a2 * term) >> 30) / 72;
        term = (64'd1 << 30) - ((a2 * term) >> 30) / 42;
        term = (64'd1 << 30) - ((a2 * term) >> 30) / 20;
        term = (64'd1 << 30) - ((a2 * term) >> 30) / 6;
        s = (a * term) >> 30;
        r = (s + 64'd16384) >> 15;
        return (r > 64'd32767) ? 16'd32767 : r[15:0];
    endfunction

    function automatic t_gain_tab build_gain();
        t_gain_tab t;
        for (int n = 0; n < SINE_TABLE_DEPTH; n++) t[n] = sine_entry(n);
        return t;
    endfunction

    function automatic logic [63:0] octave_base(int unsigned k);
        logic [63:0] b;
        case (k)
            0: b = 64'd133952;   1: b = 64'd141918;   2: b = 64'd150356;
            3: b = 64'd159297;   4: b = 64'd168769;   5: b = 64'd178805;
            6: b = 64'd189437;   7: b = 64'd200702;   8: b = 64'd212636;
            9: b = 64'd225280;  10: b = 64'd238676;
            default: b = 64'd252868;
        endcase
        return b;
    endfunction

    function automatic t_note_tab build_note();
        t_note_tab t;
        logic [63:0] v;
        for (int n = 0; n < 128; n++) begin
            v = ((octave_base(n % 12) << (n / 12)) + 64'd512) >> 10;
            t[n] = (v > 64'd65535) ? 16'hFFFF : v[15:0];
        end
        return t;
    endfunction

    localparam t_gain_tab GAIN_TAB = build_gain();
    localparam t_note_tab NOTE_TAB = build_note();

    // Arithmetic shift right that rounds toward zero.
    function automatic logic signed [59:0] trunc_sh(logic signed [59:0] x, int sh);
        logic signed [59:0] bias;
        bias = (60'sd1 <<< sh) - 60'sd1;
        return x[59] ? ((x + bias) >>> sh) : (x >>> sh);
    endfunction

    // Read addresses and interpolation weight of one tap.
    function automatic t_tap tap_calc(logic [PH_W-1:0] ph, logic [AW-1:0] wp);
        t_tap t;
        logic [WIN_W:0] back;
        logic nz;
        nz = |ph[PH_W-1-WIN_W:0];
        back = {1'b0, ph[PH_W-1 -: WIN_W]} + (WIN_W+1)'(nz);
        t.i0 = wp - AW'(back);
        t.i1 = t.i0 + AW'(1);
        t.w = nz ? (25'd16777216 - {1'b0, ph[PH_W-1-WIN_W:0], {WIN_W{1'b0}}}) : 25'd0;
        return t;
    endfunction

endpackage

>>> src/dlpc_in_if.sv
// Input channel of the pitch corrector: handshake plus one sample item.
// Depends on nothing.
interface dlpc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_in;
    logic               voiced;
    logic               note_valid;
    logic [6:0]         note_number;
    logic [15:0]        pitch_hz_q4;

    modport source (output valid, sample_in, voiced, note_valid, note_number, pitch_hz_q4,
                    input ready);
    modport sink   (input valid, sample_in, voiced, note_valid, note_number, pitch_hz_q4,
                    output ready);
endinterface

>>> src/dlpc_out_if.sv
// Output channel of the pitch corrector: handshake plus one mixed sample.
// Depends on nothing.
interface dlpc_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] sample_out;

    modport source (output valid, sample_out, input ready);
    modport sink   (input valid, sample_out, output ready);
endinterface

>>> src/delay_line_pitch_corrector.sv
// Two-tap crossfaded delay-line pitch corrector. One sample item in, one
// mixed sample out. Items that are unvoiced, carry no note, have zero pitch
// or a note-to-pitch ratio of two or more skip the 4-bit-per-cycle divider;
// all others pass through it before the rest of the sequence. A new item is
// taken only in the idle state, once the previous item is through. One
// shared 33x26 multiplier and the single delay memory set the sequence. The
// delay memory starts as silence: entries not yet written since reset read as
// zero. A new item is accepted while the previous result waits at the output;
// a result still waiting when the next one is ready holds the block in its
// last step until the output is taken.
`include "assert_macros.svh"

module delay_line_pitch_corrector
    import dlpc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    dlpc_in_if.sink           i_in,
    dlpc_out_if.source        o_out,
    input  logic              i_cfg_we,
    input  logic [CFG_IW-1:0] i_cfg_idx,
    input  logic [CFG_DW-1:0] i_cfg_data
);

    t_state r_state, n_state;
    t_tgt_mode r_mode;

    logic [CFG_DW-1:0]  r_cr, r_cw;
    logic signed [31:0] r_ratio, r_wet, r_tgt;
    logic [PH_W-1:0]    r_phasor;
    logic [AW-1:0]      r_wp;
    logic               r_full;
    logic signed [15:0] r_s;
    logic               r_voiced;
    logic [16:0]        r_rem;
    logic [15:0]        r_p;
    logic [31:0]        r_quo;
    logic [2:0]         r_cnt;
    logic [15:0]        mem [DELAY_DEPTH];
    logic [15:0]        r_q0, r_q1;
    logic               r_v0, r_v1;
    logic signed [58:0] r_prod;
    logic signed [59:0] r_acc;
    logic signed [15:0] r_a, r_tap0, r_tap1;
    logic signed [17:0] r_y15;
    logic signed [15:0] r_out;
    logic               r_out_valid;

    logic               accept, rd_en, out_load;
    logic [AW-1:0]      ra0, ra1;
    logic signed [32:0] m_a;
    logic signed [25:0] m_b;
    logic [16:0]        n_rem;
    logic [31:0]        n_quo;
    logic               go;
    logic [15:0]        nf;
    logic [PH_W-1:0]    ph1;
    t_tap               tp0, tp1;
    logic [CFG_DW-1:0]  cr_c, cw_c;
    logic signed [15:0] a_dat, b_dat;
    logic signed [59:0] prod_x, sum_x, upd, mix_o;
    logic signed [31:0] tgt_c, wtgt;

    assign ph1 = r_phasor + PHASE_HALF;
    assign tp0 = tap_calc(r_phasor, r_wp);
    assign tp1 = tap_calc(ph1, r_wp);
    assign cr_c = (r_cr > COEF_UNITY) ? COEF_UNITY : r_cr;
    assign cw_c = (r_cw > COEF_UNITY) ? COEF_UNITY : r_cw;
    assign a_dat = r_v0 ? $signed(r_q0) : 16'sd0;
    assign b_dat = r_v1 ? $signed(r_q1) : 16'sd0;
    assign prod_x = 60'(r_prod);
    assign sum_x = r_acc + prod_x;
    assign upd = trunc_sh(prod_x, 24);
    assign mix_o = trunc_sh(sum_x, 30);
    assign wtgt = r_voiced ? Q30_ONE : 32'sd0;
    assign nf = NOTE_TAB[i_in.note_number];
    assign go = i_in.voiced && i_in.note_valid && (i_in.pitch_hz_q4 != 16'd0);

    // restoring divider, DIV_STEPS quotient bits per cycle
    always_comb begin
        n_rem = r_rem;
        n_quo = r_quo;
        for (int k = 0; k < DIV_STEPS; k++) begin
            if (n_rem >= {1'b0, r_p}) begin
                n_rem = n_rem - {1'b0, r_p};
                n_quo = {n_quo[30:0], 1'b1};
            end else begin
                n_quo = {n_quo[30:0], 1'b0};
            end
            n_rem = {n_rem[15:0], 1'b0};
        end
    end

    always_comb begin
        unique case (r_mode)
            TGT_ONE:  tgt_c = Q30_ONE;
            TGT_HIGH: tgt_c = RATIO_HIGH;
            default: begin
                if ($signed({1'b0, r_quo[31:1]}) < RATIO_LOW) tgt_c = RATIO_LOW;
                else if ($signed({1'b0, r_quo[31:1]}) > RATIO_HIGH) tgt_c = RATIO_HIGH;
                else tgt_c = $signed({1'b0, r_quo[31:1]});
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = (go && ({1'b0, nf} < {i_in.pitch_hz_q4, 1'b0}))
                                         ? S_DIV : S_TGT;
            S_DIV:  if (r_cnt == 3'd7) n_state = S_TGT;
            S_TGT:  n_state = S_MR;
            S_MR:   n_state = S_MW;
            S_MW:   n_state = S_PH;
            S_PH:   n_state = S_RD0;
            S_RD0:  n_state = S_TAP0;
            S_TAP0: n_state = S_TAP1;
            S_TAP1: n_state = S_G0;
            S_G0:   n_state = S_G1;
            S_G1:   n_state = S_Y;
            S_Y:    n_state = S_MX0;
            S_MX0:  n_state = S_MX1;
            S_MX1:  n_state = S_OUT;
            S_OUT:  if (out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs and multiplier operands
    always_comb begin
        accept   = (r_state == S_IDLE) && i_in.valid;
        rd_en    = (r_state == S_RD0) || (r_state == S_TAP0);
        ra0      = (r_state == S_RD0) ? tp0.i0 : tp1.i0;
        ra1      = (r_state == S_RD0) ? tp0.i1 : tp1.i1;
        out_load = (r_state == S_OUT) && (!r_out_valid || o_out.ready);
        m_a = 33'sd0;
        m_b = 26'sd0;
        unique case (r_state)
            S_MR: begin
                m_a = 33'(r_tgt) - 33'(r_ratio);
                m_b = $signed({1'b0, cr_c});
            end
            S_MW: begin
                m_a = 33'(wtgt) - 33'(r_wet);
                m_b = $signed({1'b0, cw_c});
            end
            S_TAP0: begin
                m_a = 33'(b_dat) - 33'(a_dat);
                m_b = $signed({1'b0, tp0.w});
            end
            S_TAP1: begin
                m_a = 33'(b_dat) - 33'(a_dat);
                m_b = $signed({1'b0, tp1.w});
            end
            S_G0: begin
                m_a = 33'(r_tap0);
                m_b = $signed({10'd0, GAIN_TAB[r_phasor[PH_W-1 -: SIN_W]]});
            end
            S_G1: begin
                m_a = 33'(r_tap1);
                m_b = $signed({10'd0, GAIN_TAB[ph1[PH_W-1 -: SIN_W]]});
            end
            S_MX0: begin
                m_a = 33'(r_wet);
                m_b = 26'(r_y15);
            end
            S_MX1: begin
                m_a = 33'(Q30_ONE) - 33'(r_wet);
                m_b = 26'(r_s);
            end
            default: ;
        endcase
    end

    assign i_in.ready = (r_state == S_IDLE);
    assign o_out.valid = r_out_valid;
    assign o_out.sample_out = r_out;

    // delay memory: write on accept, two registered reads
    always_ff @(posedge i_clk) begin
        if (accept) mem[r_wp] <= i_in.sample_in;
        if (rd_en) begin
            r_q0 <= mem[ra0];
            r_q1 <= mem[ra1];
            r_v0 <= r_full || (ra0 <= r_wp);
            r_v1 <= r_full || (ra1 <= r_wp);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cr        <= RATIO_COEF_RST;
            r_cw        <= WET_COEF_RST;
            r_ratio     <= Q30_ONE;
            r_wet       <= 32'sd0;
            r_phasor    <= '0;
            r_wp        <= '0;
            r_full      <= 1'b0;
            r_out_valid <= 1'b0;
            r_cnt       <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_RATIO_COEF: r_cr <= i_cfg_data;
                    REG_WET_COEF:   r_cw <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == S_DIV) r_cnt <= r_cnt + 3'd1;
            else r_cnt <= '0;
            if (r_state == S_MW) r_ratio <= r_ratio + 32'(upd);
            if (r_state == S_PH) begin
                r_wet <= r_wet + 32'(upd);
                r_phasor <= r_phasor + PH_W'(trunc_sh(60'(Q30_ONE - r_ratio), STEP_SH));
            end
            if (out_load) begin
                r_wp <= r_wp + AW'(1);
                if (r_wp == AW'(DELAY_DEPTH - 1)) r_full <= 1'b1;
            end
            if (out_load) r_out_valid <= 1'b1;
            else if (o_out.ready) r_out_valid <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s      <= i_in.sample_in;
            r_voiced <= i_in.voiced;
            r_rem    <= {1'b0, nf};
            r_p      <= i_in.pitch_hz_q4;
            r_quo    <= '0;
            if (!go) r_mode <= TGT_ONE;
            else if ({1'b0, nf} >= {i_in.pitch_hz_q4, 1'b0}) r_mode <= TGT_HIGH;
            else r_mode <= TGT_DIV;
        end
        if (r_state == S_DIV) begin
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
        if (r_state == S_TGT) r_tgt <= tgt_c;
        if (r_state != S_OUT) r_prod <= m_a * m_b;
        if (r_state == S_TAP0) r_a <= a_dat;
        if (r_state == S_TAP1) begin
            r_tap0 <= 16'(r_a + 16'(upd));
            r_a    <= a_dat;
        end
        if (r_state == S_G0) r_tap1 <= 16'(r_a + 16'(upd));
        if (r_state == S_G1 || r_state == S_MX1) r_acc <= prod_x;
        if (r_state == S_Y) r_y15 <= 18'(trunc_sh(sum_x, 15));
        if (out_load) begin
            if (mix_o > 60'sd32767) r_out <= 16'sd32767;
            else if (mix_o < -60'sd32768) r_out <= -16'sd32768;
            else r_out <= 16'(mix_o);
        end
    end

    `DLPC_ASSERT(a_ratio_range, (r_ratio >= RATIO_LOW) && (r_ratio <= RATIO_HIGH), "ratio range")
    `DLPC_ASSERT(a_wet_range, (r_wet >= 32'sd0) && (r_wet <= Q30_ONE), "wet level out of range")
    `DLPC_ASSERT_NEXT(a_wp_step, out_load, r_wp == $past(r_wp) + AW'(1), "write pointer stuck")
    `DLPC_ASSERT_NEXT(a_out_valid, out_load, r_out_valid, "result not presented")
    `DLPC_ASSERT_NEXT(a_busy, accept, r_state != S_IDLE, "item accepted while busy path idle")

endmodule
